// ===== rtl/core/slug_pkg.sv =====
package slug_pkg;

  // Lehmer generator constants
  localparam int unsigned LEHMER_MULT_W = 15;
  localparam logic [LEHMER_MULT_W-1:0] LEHMER_MULT = 15'd16807;
  localparam int unsigned VALUE_W = 31;
  localparam logic [VALUE_W-1:0] LEHMER_MOD = 31'h7fff_ffff;

  // Shuffle table defaults
  localparam int unsigned TABLE_SIZE_DEF = 32;
  localparam int unsigned WARMUP_EXTRA = 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_FOLD,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic mul;        // register both products
    logic load_seed;  // load generator from seed (or one)
    logic use_seed;   // take seed port rather than one
    logic cnt_load;   // load warm-up counter
    logic init_fold;  // warm-up step: fold, fill table, count down
    logic draw_fold;  // draw step: fold, read table slot
    logic commit;     // emit slot value, refill slot
    logic inited;     // flag carried to the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_zero;
    logic cnt_zero;
  } status_t;

endpackage

// ===== rtl/core/slug_ctrl.sv =====
module slug_ctrl
  import slug_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    op,
  output logic    req_stall,
  output logic    res_valid,
  input  logic    res_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   inited;
  logic   accept;
  logic   need_init;
  logic   res_free;

  assign accept    = (state == ST_IDLE) && req_valid;
  assign need_init = op || status.last_zero;
  assign res_free  = !res_valid || !res_stall;
  assign req_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = need_init ? ST_INIT_MUL : ST_DRAW_FOLD;
        end
      end
      ST_INIT_MUL:  state_next = ST_INIT_FOLD;
      ST_INIT_FOLD: state_next = status.cnt_zero ? ST_DRAW_MUL : ST_INIT_MUL;
      ST_DRAW_MUL:  state_next = ST_DRAW_FOLD;
      ST_DRAW_FOLD: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.use_seed = op;
    cmd.inited   = inited;
    unique case (state)
      ST_IDLE: begin
        cmd.mul       = 1'b1;
        cmd.load_seed = accept && need_init;
        cmd.cnt_load  = accept && need_init;
      end
      ST_INIT_MUL:  cmd.mul       = 1'b1;
      ST_INIT_FOLD: cmd.init_fold = 1'b1;
      ST_DRAW_MUL:  cmd.mul       = 1'b1;
      ST_DRAW_FOLD: cmd.draw_fold = 1'b1;
      ST_COMMIT:    cmd.commit    = res_free;
      default: ;
    endcase
  end

  // State, init flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      inited    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        inited <= need_init;
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/slug_datapath.sv =====
module slug_datapath
  import slug_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] seed,
  input  cmd_t               cmd,
  output status_t            status,
  output logic [VALUE_W-1:0] sample,
  output logic               was_initialized
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W = $clog2(TABLE_SIZE + WARMUP_EXTRA);
  localparam int unsigned PROD_W = VALUE_W + LEHMER_MULT_W;

  // Slot = last / SLOT_DIV by exact reciprocal multiply
  localparam logic [63:0] SLOT_DIV = 64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_SIZE);
  localparam int unsigned SLOT_L = $clog2(SLOT_DIV);
  localparam int unsigned SLOT_SHIFT = VALUE_W + SLOT_L;
  localparam logic [63:0] SLOT_POW = 64'd1 << SLOT_SHIFT;
  localparam logic [63:0] SLOT_RECIP_FULL = (SLOT_POW + SLOT_DIV - 64'd1) / SLOT_DIV;
  localparam int unsigned RECIP_W = 33;
  localparam logic [RECIP_W-1:0] SLOT_RECIP = SLOT_RECIP_FULL[RECIP_W-1:0];
  localparam int unsigned SPROD_W = VALUE_W + RECIP_W;
  localparam int unsigned Q_W = SPROD_W - SLOT_SHIFT;

  logic [VALUE_W-1:0] gen;
  logic [VALUE_W-1:0] last;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  prod;
  logic [SPROD_W-1:0] slot_prod;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   slot_reg;
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] table_mem [TABLE_SIZE];

  logic [VALUE_W:0]   fold_sum;
  logic [VALUE_W-1:0] fold_val;
  logic [VALUE_W-1:0] seed_fix;
  logic [Q_W-1:0]     q_full;
  logic               cnt_in_table;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // Fold the product: 2^31 = 1 mod (2^31 - 1)
  always_comb begin
    fold_sum = {1'b0, prod[VALUE_W-1:0]}
             + (VALUE_W + 1)'(prod[PROD_W-1:VALUE_W]);
    if (fold_sum >= {1'b0, LEHMER_MOD}) begin
      fold_sum = fold_sum - {1'b0, LEHMER_MOD};
    end
    fold_val = fold_sum[VALUE_W-1:0];
  end

  // Map a zero seed and the modulus to one; use one when the seed port is not taken
  always_comb begin
    if (!cmd.use_seed || seed == '0 || seed == LEHMER_MOD) begin
      seed_fix = VALUE_W'(1);
    end else begin
      seed_fix = seed;
    end
  end

  // Slot index with guard clamp
  always_comb begin
    q_full = slot_prod[SPROD_W-1:SLOT_SHIFT];
    if (32'(q_full) >= 32'(TABLE_SIZE)) begin
      slot = IDX_W'(TABLE_SIZE - 1);
    end else begin
      slot = q_full[IDX_W-1:0];
    end
  end

  assign cnt_in_table     = 32'(cnt) < 32'(TABLE_SIZE);
  assign status.cnt_zero  = (cnt == '0);
  assign status.last_zero = (last == '0);

  // Table write port: warm-up fill or refill on commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_reg;
    wr_data = gen;
    if (cmd.init_fold) begin
      wr_en   = cnt_in_table;
      wr_addr = cnt[IDX_W-1:0];
      wr_data = fold_val;
    end else if (cmd.commit) begin
      wr_en = 1'b1;
    end
  end

  // Shuffle table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (cmd.draw_fold) begin
      rd_data <= table_mem[slot];
    end
  end

  // Products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod      <= LEHMER_MULT * gen;
      slot_prod <= SLOT_RECIP * last;
    end
    if (cmd.draw_fold) begin
      slot_reg <= slot;
    end
  end

  // Generator, last output and warm-up counter
  always_ff @(posedge clk) begin
    if (rst) begin
      gen  <= '0;
      last <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.load_seed) begin
        gen <= seed_fix;
      end else if (cmd.init_fold || cmd.draw_fold) begin
        gen <= fold_val;
      end
      if (cmd.cnt_load) begin
        cnt <= CNT_W'(TABLE_SIZE + WARMUP_EXTRA - 1);
      end else if (cmd.init_fold && cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.init_fold && cnt == '0) begin
        last <= fold_val;
      end else if (cmd.commit) begin
        last <= rd_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample          <= rd_data;
      was_initialized <= cmd.inited;
    end
  end

endmodule

// ===== rtl/core/shuffled_lehmer_uniform_generator.sv =====
// Channel  Handshake              Payload
// request  req_valid, req_stall   op, seed
// result   res_valid, res_stall   sample, was_initialized
//
// A draw runs from accept through the fold and table read to the commit into
// the result register; the next item is accepted in the cycle after. The
// Lehmer step is a registered multiply then a fold, and the table slot is read
// through a registered memory port. A reseed, or the first draw after reset,
// adds a warm-up of TABLE_SIZE + 8 steps, each a multiply then a fold.
// Reset (rst, synchronous) clears the generator and marks the table empty.
// A stalled result holds the block before the commit; one item may be taken
// while an earlier result waits.
module shuffled_lehmer_uniform_generator
  import slug_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               op,
  input  logic [VALUE_W-1:0] seed,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [VALUE_W-1:0] sample,
  output logic               was_initialized
);

  cmd_t    cmd;
  status_t status;

  // Sequence control
  slug_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (op),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Generator, shuffle table and result register
  slug_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .seed            (seed),
    .cmd             (cmd),
    .status          (status),
    .sample          (sample),
    .was_initialized (was_initialized)
  );

endmodule
